// File: design/tti_pkg.sv
// ----------------------------------------------------------------------------
// TTI coefficient package
// Shared widths, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package tti_pkg;

  localparam int AngW   = 33;
  localparam int CordW  = 34;
  localparam int AtanN  = 24;

  localparam logic signed [AngW-1:0] AngPi     = 33'sd843314857;
  localparam logic signed [AngW-1:0] AngTwoPi  = 33'sd1686629713;
  localparam logic signed [AngW-1:0] AngHalfPi = 33'sd421657428;
  localparam logic signed [CordW-1:0] InvGain  = 34'sd652032874;

  typedef logic signed [AngW-1:0]  ang_t;
  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [15:0]      q15_t;

  function automatic ang_t atan_q28(input int idx);
    case (idx)
      0: atan_q28 = 33'sd210828714;
      1: atan_q28 = 33'sd124459457;
      2: atan_q28 = 33'sd65760959;
      3: atan_q28 = 33'sd33381290;
      4: atan_q28 = 33'sd16755422;
      5: atan_q28 = 33'sd8385879;
      6: atan_q28 = 33'sd4193963;
      7: atan_q28 = 33'sd2097109;
      8: atan_q28 = 33'sd1048571;
      9: atan_q28 = 33'sd524287;
      10: atan_q28 = 33'sd262144;
      11: atan_q28 = 33'sd131072;
      12: atan_q28 = 33'sd65536;
      13: atan_q28 = 33'sd32768;
      14: atan_q28 = 33'sd16384;
      15: atan_q28 = 33'sd8192;
      16: atan_q28 = 33'sd4096;
      17: atan_q28 = 33'sd2048;
      18: atan_q28 = 33'sd1024;
      19: atan_q28 = 33'sd512;
      20: atan_q28 = 33'sd256;
      21: atan_q28 = 33'sd128;
      22: atan_q28 = 33'sd64;
      23: atan_q28 = 33'sd32;
      default: atan_q28 = '0;
    endcase
  endfunction

  function automatic q15_t sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) sat16 = 16'sh7fff;
    else if (v < -36'sd32768) sat16 = 16'sh8000;
    else sat16 = v[15:0];
  endfunction

  function automatic q15_t mul_q15(input q15_t a, input q15_t b);
    logic signed [31:0] p;
    logic signed [35:0] r;
    p = a * b;
    r = 36'(($signed({{4{p[31]}}, p}) + 36'sd16384) >>> 15);
    mul_q15 = sat16(r);
  endfunction

endpackage

// File: design/tti_cell_coefficients.sv
// ----------------------------------------------------------------------------
// TTI cell coefficients
// Direction coefficients and velocity squares for one cell per cycle.
// ----------------------------------------------------------------------------
//  Channel   Ports                  Transfer
//  input     start, busy, in_*      start high while busy low
//  result    out_valid, out_*       one cycle with out_valid high
//
// One cell is taken in every cycle; busy is always low. A result appears
// once its transfer has passed the CORDIC stage chain and then two
// multiplier stages. Reset clears only the valid bits. The receiver
// cannot stall, so nothing ever backs up.
module tti_cell_coefficients #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] in_tilt_angle,
  input  logic signed [15:0] in_azimuth_angle,
  input  logic [15:0] in_shear_velocity,
  input  logic [15:0] in_p_velocity,
  input  logic signed [15:0] in_epsilon_param,
  input  logic signed [15:0] in_delta_param,
  output logic        out_valid,
  output logic signed [15:0] out_coef_xx,
  output logic signed [15:0] out_coef_yy,
  output logic signed [15:0] out_coef_zz,
  output logic signed [15:0] out_coef_xy,
  output logic signed [15:0] out_coef_yz,
  output logic signed [15:0] out_coef_xz,
  output logic [31:0] out_shear_sq,
  output logic [31:0] out_p_vertical_sq,
  output logic [35:0] out_p_horizontal_sq,
  output logic [35:0] out_p_nmo_sq
);

  localparam int Run = (CORDIC_STAGES < tti_pkg::AtanN) ? CORDIC_STAGES : tti_pkg::AtanN;
  localparam int Lat = Run + 4;

  logic [Lat-1:0] vld_r;
  tti_pkg::ang_t a1, a2, p1, p2;
  tti_pkg::q15_t st, ct, s2t, c2t, sp, cp, s2p, c2p;
  tti_pkg::q15_t st2_r, cp2_r, sp2_r, zz_r, s2p_r, s2t_r, sp_r, cp_r;
  logic [31:0] vs2, vp2;
  logic [35:0] ph, pn;

  assign busy = 1'b0;
  assign a1 = tti_pkg::ang_t'(in_tilt_angle) <<< 15;
  assign a2 = tti_pkg::ang_t'(in_tilt_angle) <<< 16;
  assign p1 = tti_pkg::ang_t'(in_azimuth_angle) <<< 15;
  assign p2 = tti_pkg::ang_t'(in_azimuth_angle) <<< 16;

  tti_cordic #(.STAGES(CORDIC_STAGES)) u_t1 (.clk, .in_valid(start), .in_angle(a1),
    .out_sin(st), .out_cos(ct));
  tti_cordic #(.STAGES(CORDIC_STAGES)) u_t2 (.clk, .in_valid(start), .in_angle(a2),
    .out_sin(s2t), .out_cos(c2t));
  tti_cordic #(.STAGES(CORDIC_STAGES)) u_p1 (.clk, .in_valid(start), .in_angle(p1),
    .out_sin(sp), .out_cos(cp));
  tti_cordic #(.STAGES(CORDIC_STAGES)) u_p2 (.clk, .in_valid(start), .in_angle(p2),
    .out_sin(s2p), .out_cos(c2p));

  tti_velocity #(.LATENCY(Lat)) u_vel (
    .clk, .in_vs(in_shear_velocity), .in_vp(in_p_velocity),
    .in_eps(in_epsilon_param), .in_del(in_delta_param),
    .out_vs2(vs2), .out_vp2(vp2), .out_ph(ph), .out_pn(pn)
  );

  always_ff @(posedge clk) begin
    st2_r <= tti_pkg::mul_q15(st, st);
    cp2_r <= tti_pkg::mul_q15(cp, cp);
    sp2_r <= tti_pkg::mul_q15(sp, sp);
    zz_r  <= tti_pkg::mul_q15(ct, ct);
    s2p_r <= s2p;
    s2t_r <= s2t;
    sp_r  <= sp;
    cp_r  <= cp;
    out_coef_xx <= tti_pkg::mul_q15(st2_r, cp2_r);
    out_coef_yy <= tti_pkg::mul_q15(st2_r, sp2_r);
    out_coef_zz <= zz_r;
    out_coef_xy <= tti_pkg::mul_q15(st2_r, s2p_r);
    out_coef_yz <= tti_pkg::mul_q15(s2t_r, sp_r);
    out_coef_xz <= tti_pkg::mul_q15(s2t_r, cp_r);
  end

  assign out_shear_sq        = vs2;
  assign out_p_vertical_sq   = vp2;
  assign out_p_horizontal_sq = ph;
  assign out_p_nmo_sq        = pn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Lat-2:0], start};
    end
  end

  assign out_valid = vld_r[Lat-1];

endmodule

// File: design/tti_cordic.sv
// ----------------------------------------------------------------------------
// TTI CORDIC pipeline
// Range reduction followed by one registered CORDIC rotation per stage.
// ----------------------------------------------------------------------------
module tti_cordic #(
  parameter int STAGES = 16
) (
  input  logic          clk,
  input  logic          in_valid,
  input  tti_pkg::ang_t in_angle,
  output tti_pkg::q15_t out_sin,
  output tti_pkg::q15_t out_cos
);

  localparam int Run = (STAGES < tti_pkg::AtanN) ? STAGES : tti_pkg::AtanN;

  tti_pkg::cord_t x_r [0:Run];
  tti_pkg::cord_t y_r [0:Run];
  tti_pkg::ang_t  z_r [0:Run];
  logic           neg_r [0:Run];
  tti_pkg::ang_t  red_nxt;
  logic           neg_nxt;
  tti_pkg::cord_t xf, yf;
  logic signed [tti_pkg::CordW:0] xr, yr;

  always_comb begin
    red_nxt = in_angle;
    for (int k = 0; k < 2; k++) begin
      if (red_nxt > tti_pkg::AngPi) red_nxt = red_nxt - tti_pkg::AngTwoPi;
      else if (red_nxt < -tti_pkg::AngPi) red_nxt = red_nxt + tti_pkg::AngTwoPi;
    end
    neg_nxt = 1'b0;
    if (red_nxt > tti_pkg::AngHalfPi) begin
      red_nxt = red_nxt - tti_pkg::AngPi;
      neg_nxt = 1'b1;
    end else if (red_nxt < -tti_pkg::AngHalfPi) begin
      red_nxt = red_nxt + tti_pkg::AngPi;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      x_r[0]   <= tti_pkg::InvGain;
      y_r[0]   <= '0;
      z_r[0]   <= red_nxt;
      neg_r[0] <= neg_nxt;
    end
  end

  for (genvar i = 0; i < Run; i++) begin : g_stage
    always_ff @(posedge clk) begin
      neg_r[i+1] <= neg_r[i];
      if (!z_r[i][tti_pkg::AngW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - tti_pkg::atan_q28(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + tti_pkg::atan_q28(i);
      end
    end
  end

  always_comb begin
    xf = neg_r[Run] ? -x_r[Run] : x_r[Run];
    yf = neg_r[Run] ? -y_r[Run] : y_r[Run];
    xr = ($signed({xf[tti_pkg::CordW-1], xf}) + 35'sd16384) >>> 15;
    yr = ($signed({yf[tti_pkg::CordW-1], yf}) + 35'sd16384) >>> 15;
  end

  always_ff @(posedge clk) begin
    out_cos <= tti_pkg::sat16(36'(xr));
    out_sin <= tti_pkg::sat16(36'(yr));
  end

endmodule

// File: design/tti_velocity.sv
// ----------------------------------------------------------------------------
// TTI velocity squares
// Squares the velocities and scales the P square by the Thomsen factors.
// ----------------------------------------------------------------------------
module tti_velocity #(
  parameter int LATENCY = 19
) (
  input  logic        clk,
  input  logic [15:0] in_vs,
  input  logic [15:0] in_vp,
  input  logic signed [15:0] in_eps,
  input  logic signed [15:0] in_del,
  output logic [31:0] out_vs2,
  output logic [31:0] out_vp2,
  output logic [35:0] out_ph,
  output logic [35:0] out_pn
);

  logic [31:0] vs2_r [0:LATENCY-1];
  logic [31:0] vp2_r [0:LATENCY-1];
  logic [35:0] ph_r  [0:LATENCY-1];
  logic [35:0] pn_r  [0:LATENCY-1];
  logic signed [17:0] fe_r, fd_r;
  logic signed [49:0] pe_nxt, pd_nxt;

  function automatic logic [35:0] scale(input logic signed [49:0] p);
    logic signed [49:0] r;
    r = (p + 50'sd8192) >>> 14;
    if (p < 0) scale = '0;
    else if (r > 50'sd68719476735) scale = '1;
    else scale = r[35:0];
  endfunction

  always_ff @(posedge clk) begin
    vs2_r[0] <= in_vs * in_vs;
    vp2_r[0] <= in_vp * in_vp;
    fe_r <= 18'sd16384 + 18'(in_eps) * 18'sd2;
    fd_r <= 18'sd16384 + 18'(in_del) * 18'sd2;
  end

  assign pe_nxt = $signed({1'b0, vp2_r[0]}) * fe_r;
  assign pd_nxt = $signed({1'b0, vp2_r[0]}) * fd_r;

  always_ff @(posedge clk) begin
    vs2_r[1] <= vs2_r[0];
    vp2_r[1] <= vp2_r[0];
    ph_r[1]  <= scale(pe_nxt);
    pn_r[1]  <= scale(pd_nxt);
    ph_r[0]  <= '0;
    pn_r[0]  <= '0;
  end

  for (genvar i = 2; i < LATENCY; i++) begin : g_dly
    always_ff @(posedge clk) begin
      vs2_r[i] <= vs2_r[i-1];
      vp2_r[i] <= vp2_r[i-1];
      ph_r[i]  <= ph_r[i-1];
      pn_r[i]  <= pn_r[i-1];
    end
  end

  assign out_vs2 = vs2_r[LATENCY-1];
  assign out_vp2 = vp2_r[LATENCY-1];
  assign out_ph  = ph_r[LATENCY-1];
  assign out_pn  = pn_r[LATENCY-1];

endmodule
